// ===== rtl/roe_pkg.sv =====
// ----------------------------------------------------------------------------
// roe_pkg
// Shared constants, the item type that crosses the front-to-back queue and
// the back-end state type of the rank-of-each-value block.
// ----------------------------------------------------------------------------
package roe_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int RANK_W    = 6;
  localparam int GRP_N     = (MAX_ITEMS + 7) / 8;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    is_last;
    logic                    drop;
    logic [IDX_W-1:0]        idx;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMP,
    B_SUM,
    B_FIN,
    B_EMIT
  } back_state_t;

endpackage

// ===== rtl/roe_front.sv =====
// ----------------------------------------------------------------------------
// roe_front
// Input side: takes list elements, tags each with its slot in the list or
// marks it as dropped once the list is full, and hands it to the queue.
// ----------------------------------------------------------------------------
module roe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic signed [roe_pkg::VAL_W-1:0] in_value,
  input  logic                          in_is_last,
  output logic                          full,
  output logic                          q_push,
  output roe_pkg::item_t                q_item,
  input  logic                          q_full
);
  import roe_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             at_cap;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign at_cap = (count_r == CNT_W'(MAX_ITEMS));

  assign q_item.value   = in_value;
  assign q_item.is_last = in_is_last;
  assign q_item.drop    = at_cap;
  assign q_item.idx     = count_r[IDX_W-1:0];

  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      if (in_is_last) begin
        count_nxt = '0;
      end else if (!at_cap) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/roe_queue.sv =====
// ----------------------------------------------------------------------------
// roe_queue
// Short first-in first-out queue of tagged items between front and back.
// ----------------------------------------------------------------------------
module roe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  roe_pkg::item_t push_item,
  input  logic           pop,
  output roe_pkg::item_t head_item,
  output logic           full,
  output logic           empty
);
  import roe_pkg::*;

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] used_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (used_r == QCNT_W'(QDEPTH));
  assign empty     = (used_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   used_r <= used_r + QCNT_W'(1);
        2'b01:   used_r <= used_r - QCNT_W'(1);
        default: used_r <= used_r;
      endcase
    end
  end

endmodule

// ===== rtl/roe_back.sv =====
// ----------------------------------------------------------------------------
// roe_back
// Cell array and sequencer: each cell holds a stored value and the count of
// stored values below it; closing a list streams the counts out in order.
// ----------------------------------------------------------------------------
module roe_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  roe_pkg::item_t               head_item,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [roe_pkg::RANK_W-1:0]   out_rank,
  output logic                         out_last_rank,
  output logic                         out_overflow
);
  import roe_pkg::*;

  back_state_t             state_r;
  back_state_t             state_nxt;
  item_t                   item_r;

  logic signed [VAL_W-1:0] val_r [MAX_ITEMS];
  logic [RANK_W-1:0]       cnt_r [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]    lt_r;
  logic [MAX_ITEMS-1:0]    lt_now;
  logic [MAX_ITEMS-1:0]    in_list;
  logic [3:0]              grp_r [GRP_N];
  logic [GRP_N*8-1:0]      lt_pad;
  logic [CNT_W-1:0]        rank_sum;

  logic [CNT_W-1:0]        fill_r;
  logic                    ovf_r;
  logic [IDX_W-1:0]        emit_j_r;
  logic                    out_valid_r;
  logic [RANK_W-1:0]       out_rank_r;
  logic                    out_last_r;
  logic                    out_ovf_r;

  logic                    emit_go;
  logic                    emit_end;
  logic                    do_cmp;
  logic                    set_ovf;
  logic                    do_sum;
  logic                    do_fin;
  logic                    do_emit;

  assign emit_go  = !out_valid_r || pop;
  assign emit_end = (CNT_W'(emit_j_r) + CNT_W'(1) == fill_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) state_nxt = B_CMP;
      end
      B_CMP: begin
        if (item_r.drop) begin
          state_nxt = item_r.is_last ? B_EMIT : B_IDLE;
        end else begin
          state_nxt = B_SUM;
        end
      end
      B_SUM: state_nxt = B_FIN;
      B_FIN: state_nxt = item_r.is_last ? B_EMIT : B_IDLE;
      B_EMIT: begin
        if (emit_go && emit_end) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop   = 1'b0;
    do_cmp  = 1'b0;
    set_ovf = 1'b0;
    do_sum  = 1'b0;
    do_fin  = 1'b0;
    do_emit = 1'b0;
    case (state_r)
      B_IDLE:  q_pop   = !q_empty;
      B_CMP: begin
        do_cmp  = !item_r.drop;
        set_ovf = item_r.drop;
      end
      B_SUM:   do_sum  = 1'b1;
      B_FIN:   do_fin  = 1'b1;
      B_EMIT:  do_emit = emit_go;
      default: q_pop   = 1'b0;
    endcase
  end

  // compare the new value against every occupied cell
  always_comb begin
    for (int j = 0; j < MAX_ITEMS; j++) begin
      in_list[j] = (CNT_W'(j) < fill_r);
      lt_now[j]  = in_list[j] && (val_r[j] < item_r.value);
    end
  end

  assign lt_pad = (GRP_N*8)'(lt_r);

  always_comb begin
    rank_sum = '0;
    for (int g = 0; g < GRP_N; g++) begin
      rank_sum = rank_sum + CNT_W'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= head_item;
    end
    if (do_cmp) begin
      lt_r <= lt_now;
      val_r[item_r.idx] <= item_r.value;
      for (int j = 0; j < MAX_ITEMS; j++) begin
        if (in_list[j] && (item_r.value < val_r[j])) begin
          cnt_r[j] <= cnt_r[j] + RANK_W'(1);
        end
      end
    end
    if (do_sum) begin
      for (int g = 0; g < GRP_N; g++) begin
        grp_r[g] <= 4'($countones(lt_pad[g*8 +: 8]));
      end
    end
    if (do_fin) begin
      cnt_r[item_r.idx] <= RANK_W'(rank_sum);
    end
    if (do_emit) begin
      out_rank_r <= cnt_r[emit_j_r];
      out_last_r <= emit_end;
      out_ovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      emit_j_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_emit && emit_end) begin
        fill_r   <= '0;
        ovf_r    <= 1'b0;
        emit_j_r <= '0;
      end else begin
        if (do_cmp) fill_r <= fill_r + CNT_W'(1);
        if (set_ovf) ovf_r <= 1'b1;
        if (do_emit) emit_j_r <= emit_j_r + IDX_W'(1);
      end
      if (do_emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty         = !out_valid_r;
  assign out_rank      = out_rank_r;
  assign out_last_rank = out_last_r;
  assign out_overflow  = out_ovf_r;

endmodule

// ===== rtl/rank_of_each_value_core.sv =====
// ----------------------------------------------------------------------------
// rank_of_each_value_core
// Loads a list of signed values and returns each value's rank in input order.
// ----------------------------------------------------------------------------
// back end: each element goes through dequeue, compare, group count and final
//   sum (only dequeue and compare when it is dropped) before the next is taken;
//   the queue accepts 1 a cycle until its 4 entries are full
// closing a list streams out 1 rank per cycle from the cell array when popped
// reset: synchronous, active low; clears queue, fill count and output register
module rank_of_each_value_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic signed [roe_pkg::VAL_W-1:0] in_value,
  input  logic                             in_is_last,
  output logic                             empty,
  input  logic                             pop,
  output logic [roe_pkg::RANK_W-1:0]       out_rank,
  output logic                             out_last_rank,
  output logic                             out_overflow
);
  import roe_pkg::*;

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t q_item;
  item_t head_item;

  roe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_value   (in_value),
    .in_is_last (in_is_last),
    .full       (full),
    .q_push     (q_push),
    .q_item     (q_item),
    .q_full     (q_full)
  );

  roe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  roe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_item     (head_item),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_rank      (out_rank),
    .out_last_rank (out_last_rank),
    .out_overflow  (out_overflow)
  );

endmodule

// ===== test/tb_rank_of_each_value_core.sv =====
// ----------------------------------------------------------------------------
// tb_rank_of_each_value_core
// Self-checking bench for the rank-of-each-value core. Lists of signed values
// go in through the push side, and a local predictor works out each element's
// rank, the last-rank mark and the overflow flag. Every popped result is
// checked against the oldest rank still due. Both sides idle at random, and
// one phase holds off the pop side so that the core fills up and asserts full.
// ----------------------------------------------------------------------------
module tb_rank_of_each_value_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW   = roe_pkg::VAL_W;
  localparam int RW   = roe_pkg::RANK_W;
  localparam int MAXN = roe_pkg::MAX_ITEMS;

  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

  typedef struct packed {
    logic [RW-1:0] rank;
    logic          last_rank;
    logic          overflow;
  } rank_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  logic signed [VW-1:0] in_value;
  logic                 in_is_last;
  logic                 empty;
  logic                 pop;
  logic [RW-1:0]        out_rank;
  logic                 out_last_rank;
  logic                 out_overflow;

  rank_of_each_value_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_value      (in_value),
    .in_is_last    (in_is_last),
    .empty         (empty),
    .pop           (pop),
    .out_rank      (out_rank),
    .out_last_rank (out_last_rank),
    .out_overflow  (out_overflow)
  );

  // predictor state: the list being loaded and the ranks still to come out
  logic signed [VW-1:0] open_list[$];
  logic                 open_list_dropped;
  rank_result_t         ranks_due[$];
  rank_result_t         rank_seen;

  int mismatch_count;
  bit tx_no_idle;
  bit rx_no_idle;
  int rx_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("rank_of_each_value_core test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // ranks are counts of strictly smaller values among the stored values of the list
  task automatic note_accepted_value(input logic signed [VW-1:0] v, input logic last);
    int smaller;
    rank_result_t r;
    if (open_list.size() < MAXN) open_list.push_back(v);
    else open_list_dropped = 1'b1;
    if (last) begin
      for (int j = 0; j < open_list.size(); j++) begin
        smaller = 0;
        foreach (open_list[i]) begin
          if (open_list[i] < open_list[j]) smaller++;
        end
        r.rank      = RW'(smaller);
        r.last_rank = (j == open_list.size() - 1);
        r.overflow  = open_list_dropped;
        ranks_due.push_back(r);
      end
      open_list.delete();
      open_list_dropped = 1'b0;
    end
  endtask

  task automatic push_value(input logic signed [VW-1:0] v, input logic last);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    in_value   <= v;
    in_is_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    note_accepted_value(v, last);
  endtask

  function automatic logic signed [VW-1:0] pick_value();
    logic signed [VW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 6) - 3;  // small spread, plenty of duplicates
      1: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (ranks_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_edge_values();
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    // one-element lists
    push_value(VAL_MIN, 1'b1);
    push_value(VAL_MAX, 1'b1);
    // extremes with duplicates in one list
    push_value(VAL_MAX, 1'b0);
    push_value(VAL_MIN, 1'b0);
    push_value('0, 1'b0);
    push_value('1, 1'b0);
    push_value(1, 1'b0);
    push_value(VAL_MIN, 1'b0);
    push_value(VAL_MAX, 1'b0);
    push_value('0, 1'b1);
    // two equal values share rank zero
    push_value(7, 1'b0);
    push_value(7, 1'b1);
  endtask

  // fills all slots, then two items past capacity, the closing one among the dropped
  task automatic test_overflow();
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    for (int k = 0; k < MAXN + 2; k++) push_value(pick_value(), k == MAXN + 1);
  endtask

  task automatic test_random_lists(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) push_value(pick_value(), k == len - 1);
      sent += len;
    end
  endtask

  // pop side holds off while a second list keeps arriving back to back
  task automatic test_backpressure();
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b0;
    push <= 1'b0;
    @(posedge clk);
    wait_drained();
    rx_hold = 200;
    for (int k = 0; k < 6; k++) push_value(pick_value(), k == 5);
    for (int k = 0; k < 16; k++) push_value(pick_value(), k == 15);
  endtask

  initial begin : receiver
    int gap;
    pop <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = rx_no_idle ? 0 : $urandom_range(0, 8);
      if (rx_hold > 0) begin
        gap    = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (ranks_due.size() == 0) begin
        report_mismatch("unexpected rank transfer", out_rank, -1);
      end else begin
        rank_seen = ranks_due.pop_front();
        if (out_rank !== rank_seen.rank)
          report_mismatch("rank", out_rank, rank_seen.rank);
        if (out_last_rank !== rank_seen.last_rank)
          report_mismatch("last_rank", out_last_rank, rank_seen.last_rank);
        if (out_overflow !== rank_seen.overflow)
          report_mismatch("overflow", out_overflow, rank_seen.overflow);
      end
    end
  end

  initial begin
    mismatch_count    = 0;
    open_list_dropped = 1'b0;
    tx_no_idle        = 1'b0;
    rx_no_idle        = 1'b0;
    rx_hold           = 0;
    rst_n      <= 1'b0;
    push       <= 1'b0;
    in_value   <= '0;
    in_is_last <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_overflow();
    test_random_lists(10);
    test_backpressure();
    test_random_lists(10);

    push <= 1'b0;
    wait_drained();
    // a stray extra rank would show up here
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rank_of_each_value_core test passed");
    end else begin
      $display("rank_of_each_value_core test failed");
    end
    $finish;
  end

endmodule
